// ----- hdl/wedm_pkg.sv -----
`timescale 1ns / 1ps
package wedm_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int NODES_DEFAULT = 32;
	localparam int ENTRY_W = 269;
	localparam int DATA_W = 272;
	localparam int MASK_W = 32;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	typedef struct packed {
		logic [31:0] raw_length;
		logic [47:0] line_offset;
		logic [15:0] file_id;
		logic [31:0] held_mask;
		logic [4:0]  node_id;
		logic [31:0] namespace_id;
		logic [15:0] component_id;
		logic [7:0]  severity;
		logic [31:0] message_id;
		logic [47:0] timestamp;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	typedef struct packed {
		logic load;
		logic pop;
		logic emit_in;
		logic forced;
		logic last;
		logic absorb;
		logic insert;
	} cmd_t;

	typedef struct packed {
		logic enable;
		logic eos;
		logic count_zero;
		logic count_one;
		logic full;
		logic head_exp;
		logic next_exp;
		logic found;
		logic out_free;
	} stat_t;

endpackage

// ----- hdl/wedm_ctrl.sv -----
`timescale 1ns / 1ps
module wedm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  wedm_pkg::stat_t stat,
	output wedm_pkg::cmd_t  cmd
);
	import wedm_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				if (stat.eos) begin
					if (stat.count_zero) begin
						state_d = ST_IDLE;
					end else if (stat.out_free) begin
						cmd.pop = 1'b1;
						cmd.last = stat.count_one;
					end
				end else if (!stat.enable) begin
					if (stat.out_free) begin
						cmd.emit_in = 1'b1;
						cmd.last = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (!stat.count_zero && stat.head_exp) begin
					if (stat.out_free) begin
						cmd.pop = 1'b1;
						cmd.last = stat.count_one || !stat.next_exp;
					end
				end else if (stat.found) begin
					cmd.absorb = 1'b1;
					state_d = ST_IDLE;
				end else if (stat.full) begin
					if (stat.out_free) begin
						cmd.pop = 1'b1;
						cmd.forced = 1'b1;
						cmd.last = 1'b1;
						cmd.insert = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.insert = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/wedm_datapath.sv -----
`timescale 1ns / 1ps
module wedm_datapath #(
	parameter int WINDOW_DEPTH = wedm_pkg::DEPTH_DEFAULT,
	parameter int MAX_NODES = wedm_pkg::NODES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  wedm_pkg::entry_t in_entry,
	input  logic             in_eos,
	input  wedm_pkg::cmd_t   cmd,
	output wedm_pkg::stat_t  stat,
	input  logic             out_ready,
	output logic             out_valid,
	output wedm_pkg::entry_t out_entry,
	output logic             out_forced,
	output logic             out_last
);
	import wedm_pkg::*;

	localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [MASK_W-1:0] NODE_BITS = {MASK_W{1'b1}} >> (MASK_W - MAX_NODES);

	logic                 enable_q;
	logic [7:0]           window_q;
	entry_t               in_q;
	logic                 eos_q;
	logic [PW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [WINDOW_DEPTH-1:0] exp_q;
	logic [WINDOW_DEPTH-1:0] keq_q;

	logic [47:0]          time_q [WINDOW_DEPTH];
	logic [31:0]          msg_q [WINDOW_DEPTH];
	logic [7:0]           sev_q [WINDOW_DEPTH];
	logic [15:0]          comp_q [WINDOW_DEPTH];
	logic [31:0]          ns_q [WINDOW_DEPTH];
	logic [4:0]           node_q [WINDOW_DEPTH];
	logic [MAX_NODES-1:0] mask_q [WINDOW_DEPTH];
	logic [15:0]          file_q [WINDOW_DEPTH];
	logic [47:0]          off_q [WINDOW_DEPTH];
	logic [31:0]          len_q [WINDOW_DEPTH];

	logic                 out_valid_q;
	entry_t               out_q;
	logic                 out_forced_q;
	logic                 out_last_q;

	entry_t               in_m;
	logic [PW-1:0]        head_nx;
	logic [PW:0]          tail_sum;
	logic [PW-1:0]        ins_slot;
	logic [WINDOW_DEPTH-1:0] valid_v;
	logic [WINDOW_DEPTH-1:0] ge_head;
	logic [WINDOW_DEPTH-1:0] cand;
	logic [WINDOW_DEPTH-1:0] sel;
	logic [WINDOW_DEPTH-1:0] hit_oh;
	logic [WINDOW_DEPTH-1:0] exp_d;
	logic [WINDOW_DEPTH-1:0] keq_d;
	logic [PW:0]          lane_off;
	entry_t               head_e;
	logic                 out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			window_q <= 8'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			exp_d[i] = (in_entry.timestamp - time_q[i]) > 48'(window_q);
			keq_d[i] = (msg_q[i] == in_entry.message_id) && (sev_q[i] == in_entry.severity)
				&& (comp_q[i] == in_entry.component_id)
				&& (ns_q[i] == in_entry.namespace_id) && (node_q[i] != in_entry.node_id);
		end
	end

	always_comb begin
		in_m = in_entry;
		in_m.held_mask = in_entry.held_mask & NODE_BITS;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_m;
			eos_q <= in_eos;
			exp_q <= exp_d;
			keq_q <= keq_d;
		end
	end

	assign head_nx = (head_q == PW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_sum = (PW + 1)'(head_q) + (PW + 1)'(count_q);
	assign ins_slot = (tail_sum >= (PW + 1)'(WINDOW_DEPTH))
		? PW'(tail_sum - (PW + 1)'(WINDOW_DEPTH)) : PW'(tail_sum);

	always_comb begin
		lane_off = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			ge_head[i] = PW'(i) >= head_q;
			lane_off = ge_head[i] ? (PW + 1)'(i) - (PW + 1)'(head_q)
				: (PW + 1)'(i + WINDOW_DEPTH) - (PW + 1)'(head_q);
			valid_v[i] = lane_off < (PW + 1)'(count_q);
		end
		cand = valid_v & ~exp_q & keq_q;
		sel = (|(cand & ge_head)) ? (cand & ge_head) : cand;
		hit_oh = sel & (~sel + {{(WINDOW_DEPTH - 1){1'b0}}, 1'b1});
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (cmd.insert && ins_slot == PW'(i)) begin
				time_q[i] <= in_q.timestamp;
				msg_q[i] <= in_q.message_id;
				sev_q[i] <= in_q.severity;
				comp_q[i] <= in_q.component_id;
				ns_q[i] <= in_q.namespace_id;
				node_q[i] <= in_q.node_id;
				mask_q[i] <= in_q.held_mask[MAX_NODES-1:0];
				file_q[i] <= in_q.file_id;
				off_q[i] <= in_q.line_offset;
				len_q[i] <= in_q.raw_length;
			end else if (cmd.absorb && hit_oh[i]) begin
				mask_q[i] <= mask_q[i] | in_q.held_mask[MAX_NODES-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.pop) begin
				head_q <= head_nx;
			end
			if (cmd.pop && !cmd.insert) begin
				count_q <= count_q - 1'b1;
			end else if (cmd.insert && !cmd.pop) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_comb begin
		head_e.timestamp = time_q[head_q];
		head_e.message_id = msg_q[head_q];
		head_e.severity = sev_q[head_q];
		head_e.component_id = comp_q[head_q];
		head_e.namespace_id = ns_q[head_q];
		head_e.node_id = node_q[head_q];
		head_e.held_mask = MASK_W'(mask_q[head_q]);
		head_e.file_id = file_q[head_q];
		head_e.line_offset = off_q[head_q];
		head_e.raw_length = len_q[head_q];
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pop || cmd.emit_in) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop || cmd.emit_in) begin
			out_q <= cmd.emit_in ? in_q : head_e;
			out_forced_q <= cmd.forced;
			out_last_q <= cmd.last;
		end
	end

	always_comb begin
		stat.enable = enable_q;
		stat.eos = eos_q;
		stat.count_zero = count_q == '0;
		stat.count_one = count_q == CW'(1);
		stat.full = count_q == CW'(WINDOW_DEPTH);
		stat.head_exp = exp_q[head_q];
		stat.next_exp = exp_q[head_nx];
		stat.found = |cand;
		stat.out_free = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_entry = out_q;
	assign out_forced = out_forced_q;
	assign out_last = out_last_q;

endmodule

// ----- hdl/windowed_entry_dedup_merge_top.sv -----
`timescale 1ns / 1ps
// Merges duplicate log entries from different nodes within a short time window.
// Entries arrive on the s_axis channel in timestamp order; s_axis_tlast marks an
// end-of-stream item that carries no entry and flushes every pending entry.
// Released entries leave on m_axis, one item per result, with m_axis_tuser set
// when an entry was forced out by a full window and m_axis_tlast on the final
// result caused by an input item.
// The cfg channel writes register 0 (enable) and register 1 (window in ms); it is
// always ready and must only be used while the block is idle.
// An input item is taken in the idle state and handled in the work state. An item
// that releases nothing, a pass-through item and an item that forces out the oldest
// entry go back to idle from the work state; expired entries are released first, one
// by one, and an end-of-stream item releases every pending entry before the block
// returns to idle. The rate is set by the window controller, which handles one item
// at a time and emits one entry per cycle while m_axis is not stalled. Reset empties
// the window and sets enable to 1 and the window to 1 ms.
// When m_axis stalls, the single output register holds its item and the block
// waits before producing the next result; a new input item is taken only after
// the item in work has placed its last result.
module windowed_entry_dedup_merge_top #(
	parameter int WINDOW_DEPTH = wedm_pkg::DEPTH_DEFAULT,
	parameter int MAX_NODES = wedm_pkg::NODES_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [7:0]                  cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// timestamp, message_id, severity, component_id, namespace_id, node_id,
	// held_mask, file_id, line_offset, raw_length, zero fill.
	input  logic [wedm_pkg::DATA_W-1:0] s_axis_tdata,
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// out_timestamp, out_message_id, out_severity, out_component_id,
	// out_namespace_id, out_node_id, merged_mask, out_file_id, out_raw_offset,
	// out_raw_length, zero fill.
	output logic [wedm_pkg::DATA_W-1:0] m_axis_tdata,
	// forced_out.
	output logic                        m_axis_tuser,
	output logic                        m_axis_tlast
);
	import wedm_pkg::*;

	cmd_t   cmd;
	stat_t  stat;
	entry_t in_entry;
	entry_t out_entry;

	assign cfg_ready = 1'b1;
	assign in_entry = s_axis_tdata[ENTRY_W-1:0];
	assign m_axis_tdata = {{(DATA_W - ENTRY_W){1'b0}}, out_entry};

	wedm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wedm_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.MAX_NODES    (MAX_NODES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_entry   (in_entry),
		.in_eos     (s_axis_tlast),
		.cmd        (cmd),
		.stat       (stat),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_entry  (out_entry),
		.out_forced (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.count_zero)
		else $error("Pop from an empty window.");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.insert && !cmd.pop) |-> !stat.full)
		else $error("Insert into a full window.");

	a_forced_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.forced |-> (cmd.last && cmd.insert))
		else $error("Forced release must end the item and insert.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("Second item taken while one is in work.");
`endif

endmodule

// ----- tb/sv/wedm_checker.sv -----
`timescale 1ns / 1ps
module wedm_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [7:0]                  cfg_data,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [wedm_pkg::DATA_W-1:0] s_axis_tdata,
	input  logic                        s_axis_tlast,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [wedm_pkg::DATA_W-1:0] m_axis_tdata,
	input  logic                        m_axis_tuser,
	input  logic                        m_axis_tlast,
	output int                          fail_count,
	output int                          pending_count
);
	import wedm_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              forced;
		logic              last;
	} release_t;

	entry_t   win [DEPTH_DEFAULT];
	int       head;
	int       count;
	logic     merge_on;
	logic [7:0] window;
	release_t releases [$];

	assign pending_count = releases.size();

	function automatic logic [DATA_W-1:0] pack_entry(entry_t e);
		return {3'b000, e};
	endfunction

	task automatic emit(entry_t e, logic forced);
		release_t r;
		r.data = pack_entry(e);
		r.forced = forced;
		r.last = 1'b0;
		releases.insert(releases.size(), r);
	endtask

	task automatic pop_oldest(logic forced);
		emit(win[head], forced);
		head = (head + 1) % DEPTH_DEFAULT;
		count--;
	endtask

	task automatic predict_merge(entry_t e, logic eos);
		int n_prior;
		int s;
		bit absorbed;
		n_prior = releases.size();
		absorbed = 0;
		if (eos) begin
			while (count > 0) pop_oldest(1'b0);
		end else if (!merge_on) begin
			emit(e, 1'b0);
		end else begin
			while (count > 0 && 48'(e.timestamp - win[head].timestamp) > window)
				pop_oldest(1'b0);
			for (int k = 0; k < count && !absorbed; k++) begin
				s = (head + k) % DEPTH_DEFAULT;
				if (48'(e.timestamp - win[s].timestamp) <= window &&
				    win[s].message_id == e.message_id && win[s].severity == e.severity &&
				    win[s].component_id == e.component_id &&
				    win[s].namespace_id == e.namespace_id && win[s].node_id != e.node_id) begin
					win[s].held_mask = win[s].held_mask | e.held_mask;
					absorbed = 1;
				end
			end
			if (!absorbed) begin
				if (count >= DEPTH_DEFAULT) pop_oldest(1'b1);
				win[(head + count) % DEPTH_DEFAULT] = e;
				count++;
			end
		end
		if (releases.size() > n_prior) releases[releases.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		release_t exp_r;
		if (!arst_n) begin
			head = 0;
			count = 0;
			merge_on = 1'b1;
			window = 8'd1;
			fail_count <= 0;
			releases.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ENABLE) merge_on = cfg_data[0];
				else window = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (releases.size() == 0) begin
					if (fail_count < 10) $display("unexpected item %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = releases.pop_front();
					if (exp_r.data !== m_axis_tdata || exp_r.forced !== m_axis_tuser ||
					    exp_r.last !== m_axis_tlast) begin
						if (fail_count < 10)
							$display("mismatch exp %h u%b l%b got %h u%b l%b", exp_r.data,
								exp_r.forced, exp_r.last, m_axis_tdata, m_axis_tuser,
								m_axis_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_merge(entry_t'(s_axis_tdata[ENTRY_W-1:0]), s_axis_tlast);
		end
	end
endmodule

// ----- tb/sv/tb_windowed_entry_dedup_merge_top.sv -----
`timescale 1ns / 1ps
module tb_windowed_entry_dedup_merge_top;
	import wedm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	int fail_count;
	int pending_count;
	int idle_cycles;
	bit calm;
	logic [47:0] now_ms;
	entry_t pool [8];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	windowed_entry_dedup_merge_top dut (.*);

	wedm_checker checker_i (.*);

	always @(negedge clk) m_axis_tready <= calm || ($urandom_range(0, 99) >= 34);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAIL windowed_entry_dedup_merge_top");
			$finish;
		end
	end

	task automatic send(entry_t e, logic eos);
		while (!calm && $urandom_range(0, 99) < 34) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {3'b000, e};
		s_axis_tlast <= eos;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic entry_t random_entry();
		entry_t e;
		e = ENTRY_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		return e;
	endfunction

	function automatic entry_t dup_entry(logic [47:0] ts);
		entry_t e;
		e = pool[$urandom_range(0, 7)];
		e.timestamp = ts;
		e.node_id = 5'($urandom);
		e.held_mask = $urandom;
		e.file_id = 16'($urandom);
		e.line_offset = 48'({$urandom, $urandom});
		e.raw_length = $urandom;
		return e;
	endfunction

	task automatic random_phase(int n, int step_max);
		entry_t e;
		for (int i = 0; i < n; i++) begin
			now_ms = now_ms + $urandom_range(0, step_max);
			if ($urandom_range(0, 99) < 85) begin
				e = dup_entry(now_ms);
			end else begin
				e = random_entry();
				if ($urandom_range(0, 1)) e.timestamp = now_ms;
			end
			send(e, $urandom_range(0, 99) < 3);
		end
		send(random_entry(), 1'b1);
	endtask

	initial begin
		entry_t e;
		calm = 1'b0;
		idle_cycles = 0;
		now_ms = 48'd1000;
		for (int i = 0; i < 8; i++) pool[i] = random_entry();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		e = '1;
		send(e, 1'b0);
		e = '0;
		send(e, 1'b0);
		e.node_id = 5'd31;
		e.held_mask = 32'hFFFF_0000;
		send(e, 1'b0);
		e.node_id = 5'd1;
		e.timestamp = 48'd1;
		send(e, 1'b0);
		e.timestamp = 48'd3;
		send(e, 1'b0);
		e.timestamp = 48'd2;
		send(e, 1'b0);
		send(random_entry(), 1'b1);
		send(random_entry(), 1'b1);
		for (int i = 0; i < 34; i++) begin
			e = random_entry();
			e.timestamp = 48'd100;
			send(e, 1'b0);
		end
		send(e, 1'b1);

		write_reg(REG_WINDOW, 8'd255);
		random_phase(90, 8);
		write_reg(REG_WINDOW, 8'd0);
		random_phase(60, 1);
		write_reg(REG_ENABLE, 8'd0);
		random_phase(40, 3);
		write_reg(REG_ENABLE, 8'd1);
		write_reg(REG_WINDOW, 8'd20);
		calm = 1'b1;
		random_phase(80, 4);
		calm = 1'b0;
		write_reg(REG_WINDOW, 8'd100);
		random_phase(100, 12);

		s_axis_tvalid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("PASS windowed_entry_dedup_merge_top");
		else
			$display("FAIL windowed_entry_dedup_merge_top");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/wedm_pkg.sv
hdl/wedm_ctrl.sv
hdl/wedm_datapath.sv
hdl/windowed_entry_dedup_merge_top.sv
tb/sv/wedm_checker.sv
tb/sv/tb_windowed_entry_dedup_merge_top.sv
